### rtl/interleaved_sine_tone_generator_macros.svh
// Assertion macros for the top RTL file of the tone generator.
// Synthesis builds see empty bodies.
`ifndef INTERLEAVED_SINE_TONE_GENERATOR_MACROS_SVH
`define INTERLEAVED_SINE_TONE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge outside reset.
`define ISTG_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ISTG_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ISTG_CHECK(lbl, prop, msg)
`define ISTG_CHECK_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/istg_pkg.sv
package istg_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;

    localparam int QTR_SIZE = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W   = SINE_TABLE_BITS + 1;

    // The low 32 - PHASE_BITS phase bits (none when PHASE_BITS is 32) are cleared after each accumulation.
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam logic [63:0] ONE_Q31     = 64'd2147483648;

    // Divisors (2n)*(2n+1) of the Taylor terms, n = 1..7.
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic [31:0] t_sine_rom [0:QTR_SIZE];

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // One quarter-wave entry in unsigned Q31, truncating integer Taylor series.
    function automatic logic [31:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q31 * 64'(k)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 31;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 31) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q31)) begin
            sum = $signed(ONE_Q31);
        end
        if (k == 0) begin
            sum = 64'sd0;
        end
        if (k == QTR_SIZE) begin
            sum = $signed(ONE_Q31);
        end
        return sum[31:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int unsigned k = 0; k <= QTR_SIZE; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

### rtl/interleaved_sine_tone_generator.sv
// Interleaved sine tone generator. Each accepted input beat is one frame tick
// and yields one output beat per channel (channel_count, taken as 1 when zero
// and as 8 above 8), in channel order, with o_last on the final one. Output
// beats leave at one per cycle while i_out_ready is high, and frames follow
// each other without a gap when the next frame is ready; the first beat of a
// frame passes, after the edge that accepts its input beat, through the table
// read, amplitude multiply, scaling and output registers in that order. The
// serializer, emitting one channel a cycle while i_out_ready is high, sets
// the sustained rate. Registers may be written only while no frame is in flight.
module interleaved_sine_tone_generator
    import istg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_sample,
    output logic [2:0]         o_channel,
    output logic               o_last,
    output logic               o_done_res
);

`include "interleaved_sine_tone_generator_macros.svh"

    typedef enum logic [2:0] {
        CFG_PHASE_STEP     = 3'd0,
        CFG_TONE_FRAMES    = 3'd1,
        CFG_CHANNEL_COUNT  = 3'd2,
        CFG_ACTIVE_CHANNEL = 3'd3,
        CFG_AMPLITUDE      = 3'd4
    } t_cfg_index;

    logic [31:0] r_phase_step;
    logic [31:0] r_tone_frames;
    logic [3:0]  r_channel_count;
    logic [2:0]  r_active_channel;
    logic [16:0] r_amplitude;

    logic [31:0] r_phase_acc;
    logic [31:0] r_frame_index;

    logic r_s1_v, r_s2_v, r_s3_v;
    logic r_s1_neg, r_s2_neg, r_s3_neg;
    logic r_s1_done, r_s2_done, r_s3_done;

    logic               r_ov;
    logic [2:0]         r_ch;
    logic signed [31:0] r_value;
    logic               r_done;

    logic              in_acc;
    logic [31:0]       n_phase;
    logic [31:0]       n_frame;
    logic              n_done;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0] addr;
    logic [16:0]       amp_sat;
    logic [3:0]        nch;
    logic              last_beat;
    logic              ser_load;
    t_stage_en         en;
    logic [31:0]       q;
    logic              rem;

    // Effective channel count: zero counts as one, large values saturate.
    always_comb begin
        if (r_channel_count == 4'd0) begin
            nch = 4'd1;
        end else if (r_channel_count > 4'(MAX_CHANNELS)) begin
            nch = 4'(MAX_CHANNELS);
        end else begin
            nch = r_channel_count;
        end
    end

    assign amp_sat = (r_amplitude > 17'h10000) ? 17'h10000 : r_amplitude;

    // Stall chain: a stage loads when it is empty or its content moves on.
    assign last_beat  = (4'(r_ch) + 4'd1 == nch);
    assign ser_load   = !r_ov || (i_out_ready && last_beat);
    assign en.s3      = !r_s3_v || ser_load;
    assign en.s2      = !r_s2_v || en.s3;
    assign en.s1      = !r_s1_v || en.s2;
    assign o_in_ready = en.s1;
    assign in_acc     = i_in_valid && o_in_ready;

    assign n_phase = i_restart ? 32'd0 : r_phase_acc;
    assign n_frame = i_restart ? 32'd0 : r_frame_index;
    assign n_done  = (n_frame >= r_tone_frames);

    // Odd quadrants read the quarter table mirrored.
    assign idx  = n_phase[29 -: SINE_TABLE_BITS];
    assign addr = n_phase[30] ? (ADDR_W'(QTR_SIZE) - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step     <= 32'd0;
            r_tone_frames    <= 32'd0;
            r_channel_count  <= 4'd2;
            r_active_channel <= 3'd0;
            r_amplitude      <= 17'h10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:     r_phase_step     <= i_cfg_wdata;
                CFG_TONE_FRAMES:    r_tone_frames    <= i_cfg_wdata;
                CFG_CHANNEL_COUNT:  r_channel_count  <= i_cfg_wdata[3:0];
                CFG_ACTIVE_CHANNEL: r_active_channel <= i_cfg_wdata[2:0];
                CFG_AMPLITUDE:      r_amplitude      <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc   <= 32'd0;
            r_frame_index <= 32'd0;
        end else if (in_acc) begin
            if (n_done) begin
                r_phase_acc   <= n_phase;
                r_frame_index <= n_frame;
            end else begin
                r_phase_acc   <= (n_phase + r_phase_step) & PHASE_MASK;
                r_frame_index <= n_frame + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (en.s1) begin
                r_s1_v <= in_acc;
            end
            if (en.s2) begin
                r_s2_v <= r_s1_v;
            end
            if (en.s3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_s1_neg  <= n_phase[31];
            r_s1_done <= n_done;
        end
        if (en.s2) begin
            r_s2_neg  <= r_s1_neg;
            r_s2_done <= r_s1_done;
        end
        if (en.s3) begin
            r_s3_neg  <= r_s2_neg;
            r_s3_done <= r_s2_done;
        end
    end

    istg_sine_pipe u_sine (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (addr),
        .i_amp  (amp_sat),
        .o_q    (q),
        .o_rem  (rem)
    );

    // Serializer: one frame held, one channel beat per cycle while i_out_ready is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ch <= 3'd0;
        end else if (ser_load) begin
            r_ov <= r_s3_v;
            r_ch <= 3'd0;
        end else if (r_ov && i_out_ready) begin
            r_ch <= r_ch + 3'd1;
        end
    end

    // Negative samples floor toward minus infinity: -(q + rem) = ~q + !rem.
    always_ff @(posedge i_clk) begin
        if (ser_load && r_s3_v) begin
            r_value <= r_s3_neg ? $signed(~q + {31'd0, !rem}) : $signed(q);
            r_done  <= r_s3_done;
        end
    end

    assign o_out_valid = r_ov;
    assign o_channel   = r_ch;
    assign o_last      = last_beat;
    assign o_done_res  = r_done;
    assign o_sample    = (!r_done && r_ch == r_active_channel) ? r_value : 32'sd0;

    `ISTG_CHECK(a_channel_steps,
        (r_ov && i_out_ready && !last_beat) |=> (r_ov && r_ch == $past(r_ch) + 3'd1),
        "channel index did not advance within a frame")
    `ISTG_CHECK(a_frame_starts_at_zero,
        (r_ov && i_out_ready && last_beat) |=> (!r_ov || r_ch == 3'd0),
        "new frame does not start at channel zero")
    `ISTG_CHECK(a_done_is_silent,
        (r_ov && r_done) |-> (o_sample == 32'sd0),
        "nonzero sample after the tone ended")
    `ISTG_CHECK(a_done_holds_state,
        (in_acc && !i_restart && n_done) |=> ($stable(r_frame_index) && $stable(r_phase_acc)),
        "phase or frame counter moved after the tone ended")
    `ISTG_CHECK(a_channel_in_range,
        r_ov |-> (4'(r_ch) < nch),
        "channel index beyond the channel count")

endmodule

### rtl/istg_sine_pipe.sv
module istg_sine_pipe
    import istg_pkg::*;
(
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [16:0]       i_amp,
    output logic [31:0]       o_q,
    output logic              o_rem
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [31:0] r_mag;
    logic [48:0] r_m;
    logic [31:0] r_q;
    logic        r_rem;
    logic [79:0] n_prod;

    // m * (2^31 - 2) written as two shifts; the sample is this over 2^47.
    assign n_prod = {r_m, 31'd0} - {30'd0, r_m, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_mag <= SINE_ROM[i_addr];
        end
        if (i_en.s2) begin
            r_m <= 49'(i_amp) * 49'(r_mag);
        end
        if (i_en.s3) begin
            r_q   <= n_prod[78:47];
            r_rem <= |n_prod[46:0];
        end
    end

    assign o_q   = r_q;
    assign o_rem = r_rem;

endmodule
